>>> rtl/gsm_pkg.sv
// Shared codes and control types for the generational slot map.
// No dependencies; compile before every other file of the block.
`default_nettype none
package gsm_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  localparam int GRP_BITS = 3;
  localparam int GRP_SIZE = 8;

  typedef struct packed {
    logic set_all;
    logic find_grp;
    logic alloc;
    logic free_one;
  } free_ctl_t;

endpackage
`default_nettype wire

>>> rtl/gsm_if.sv
// Request and response channel interfaces of the generational slot map.
// Valid/ready handshake; widths follow the top level's parameters.
`default_nettype none
interface gsm_req_if #(
  parameter int IDW  = 6,
  parameter int GENW = 16,
  parameter int PAYW = 32
) ();
  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [IDW-1:0]  handle_id;
  logic [GENW-1:0] handle_generation;
  logic [PAYW-1:0] payload;

  modport source (output valid, req_type, handle_id, handle_generation, payload,
                  input ready);
  modport sink (input valid, req_type, handle_id, handle_generation, payload,
                output ready);
endinterface

interface gsm_rsp_if #(
  parameter int IDW  = 6,
  parameter int GENW = 16,
  parameter int PAYW = 32,
  parameter int CNTW = 7
) ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [IDW-1:0]  out_id;
  logic [GENW-1:0] out_generation;
  logic [IDW-1:0]  dense_position;
  logic [PAYW-1:0] out_payload;
  logic [CNTW-1:0] live_entries;

  modport source (output valid, status, out_id, out_generation, dense_position,
                  out_payload, live_entries, input ready);
  modport sink (input valid, status, out_id, out_generation, dense_position,
                out_payload, live_entries, output ready);
endinterface
`default_nettype wire

>>> rtl/generational_slot_map_unit.sv
// Generational slot map: handle table, dense payload store and sequencer.
// Depends on gsm_pkg, gsm_if (gsm_req_if, gsm_rsp_if) and gsm_free_trk.
//
//   channel  dir  beat contents
//   in_ch    in   req_type, handle_id, handle_generation, payload
//   out_ch   out  status, out_id, out_generation, dense_position,
//                 out_payload, live_entries
//
// One request at a time; in_ch.ready is high only while the sequencer is idle.
// Add, remove and lookup step through states that wait on the registered reads
// of the slot and dense memories, each read once per cycle; a full add and a
// clear do not. After reset the generation memory is swept to zero with
// in_ch.ready low. A result waits in a holding register; if out_ch stalls,
// the next request is still accepted and held once its own result is ready.
`default_nettype none
module generational_slot_map_unit #(
  parameter int CAPACITY     = 64,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gsm_req_if.sink    in_ch,
  gsm_rsp_if.source  out_ch
);

  localparam int IDW  = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_BIT  = 4'd2;
  localparam logic [3:0] S_ADDG = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_LKP  = 4'd5;
  localparam logic [3:0] S_RM1  = 4'd6;
  localparam logic [3:0] S_RM2  = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic [1:0]              req_r, req_nxt;
  logic [IDW-1:0]          id_r, id_nxt;
  logic [GEN_BITS-1:0]     hgen_r, hgen_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IDW-1:0]          pos_r, pos_nxt;
  logic [GEN_BITS-1:0]     gen_r, gen_nxt;
  logic [PAYLOAD_BITS-1:0] opay_r, opay_nxt;
  logic [IDW-1:0]          ls_r, ls_nxt;
  logic [IDW-1:0]          sl_r, sl_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [IDW-1:0]          sweep_r, sweep_nxt;

  logic [1:0]              res_st_r, res_st_nxt;
  logic [IDW-1:0]          res_id_r, res_id_nxt;
  logic [GEN_BITS-1:0]     res_gen_r, res_gen_nxt;
  logic [IDW-1:0]          res_pos_r, res_pos_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_st_r;
  logic [IDW-1:0]          out_id_r;
  logic [GEN_BITS-1:0]     out_gen_r;
  logic [IDW-1:0]          out_pos_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [CNTW-1:0]         out_live_r;
  logic                    out_load;

  logic                    accept, out_free, live;
  logic [IDW-1:0]          last;
  gsm_pkg::free_ctl_t      fctl;
  logic [IDW-1:0]          found_slot, trk_id;
  logic                    slot_is_free;

  // memories
  logic [GEN_BITS-1:0]     gen_mem [CAPACITY];
  logic [IDW-1:0]          s2d_mem [CAPACITY];
  logic [IDW-1:0]          d2s_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] dd_mem  [CAPACITY];

  logic                    gen_we, s2d_we, d2s_we, dd_we;
  logic [IDW-1:0]          gen_wa, s2d_wa, d2s_wa, dd_wa;
  logic [GEN_BITS-1:0]     gen_wd;
  logic [IDW-1:0]          s2d_wd, d2s_wd;
  logic [PAYLOAD_BITS-1:0] dd_wd;
  logic [IDW-1:0]          gen_ra, s2d_ra, d2s_ra, dd_ra;
  logic [GEN_BITS-1:0]     gen_rd_r;
  logic [IDW-1:0]          s2d_rd_r, d2s_rd_r;
  logic [PAYLOAD_BITS-1:0] dd_rd_r;

  gsm_free_trk #(
    .CAPACITY (CAPACITY),
    .IDW      (IDW)
  ) u_free (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (fctl),
    .slot_id      (trk_id),
    .found_slot   (found_slot),
    .slot_is_free (slot_is_free)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last        = IDW'(cnt_r - 1'b1);
  assign trk_id      = id_r;

  assign gen_ra = (state_r == S_BIT) ? found_slot : in_ch.handle_id;
  assign s2d_ra = in_ch.handle_id;
  assign d2s_ra = last;
  assign dd_ra  = (state_r == S_RM1) ? last : s2d_rd_r;

  assign live = ({1'b0, id_r} < (IDW + 1)'(CAPACITY)) && !slot_is_free
             && (gen_rd_r == hgen_r) && (cnt_r != '0)
             && (CNTW'(s2d_rd_r) < cnt_r);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    id_nxt      = id_r;
    hgen_nxt    = hgen_r;
    pay_nxt     = pay_r;
    pos_nxt     = pos_r;
    gen_nxt     = gen_r;
    opay_nxt    = opay_r;
    ls_nxt      = ls_r;
    sl_nxt      = sl_r;
    cnt_nxt     = cnt_r;
    sweep_nxt   = sweep_r;
    res_st_nxt  = res_st_r;
    res_id_nxt  = res_id_r;
    res_gen_nxt = res_gen_r;
    res_pos_nxt = res_pos_r;
    res_pay_nxt = res_pay_r;
    out_load    = 1'b0;
    fctl        = '0;
    gen_we = 1'b0; gen_wa = sweep_r; gen_wd = '0;
    s2d_we = 1'b0; s2d_wa = sl_r;    s2d_wd = pos_r;
    d2s_we = 1'b0; d2s_wa = pos_r;   d2s_wd = ls_r;
    dd_we  = 1'b0; dd_wa  = pos_r;   dd_wd  = dd_rd_r;

    case (state_r)
      S_INIT: begin
        gen_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == IDW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_ch.req_type;
          id_nxt   = in_ch.handle_id;
          hgen_nxt = in_ch.handle_generation;
          pay_nxt  = in_ch.payload;
          case (in_ch.req_type)
            gsm_pkg::REQ_ADD: begin
              if (cnt_r == CNTW'(CAPACITY)) begin
                res_st_nxt  = gsm_pkg::ST_FULL;
                res_id_nxt  = '0;
                res_gen_nxt = '0;
                res_pos_nxt = '0;
                res_pay_nxt = '0;
                state_nxt   = S_PUSH;
              end else begin
                fctl.find_grp = 1'b1;
                state_nxt     = S_BIT;
              end
            end
            gsm_pkg::REQ_REMOVE, gsm_pkg::REQ_LOOKUP: begin
              state_nxt = S_CHK;
            end
            default: begin
              fctl.set_all = 1'b1;
              cnt_nxt      = '0;
              sweep_nxt    = '0;
              state_nxt    = S_CLR;
            end
          endcase
        end
      end
      S_BIT: begin
        fctl.alloc = 1'b1;
        s2d_we     = 1'b1;
        s2d_wa     = found_slot;
        s2d_wd     = cnt_r[IDW-1:0];
        d2s_we     = 1'b1;
        d2s_wa     = cnt_r[IDW-1:0];
        d2s_wd     = found_slot;
        dd_we      = 1'b1;
        dd_wa      = cnt_r[IDW-1:0];
        dd_wd      = pay_r;
        pos_nxt    = cnt_r[IDW-1:0];
        sl_nxt     = found_slot;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = S_ADDG;
      end
      S_ADDG: begin
        res_st_nxt  = gsm_pkg::ST_OK;
        res_id_nxt  = sl_r;
        res_gen_nxt = gen_rd_r;
        res_pos_nxt = pos_r;
        res_pay_nxt = pay_r;
        state_nxt   = S_PUSH;
      end
      S_CHK: begin
        if (!live) begin
          res_st_nxt  = gsm_pkg::ST_STALE;
          res_id_nxt  = '0;
          res_gen_nxt = '0;
          res_pos_nxt = '0;
          res_pay_nxt = '0;
          state_nxt   = S_PUSH;
        end else begin
          pos_nxt   = s2d_rd_r;
          gen_nxt   = gen_rd_r;
          state_nxt = (req_r == gsm_pkg::REQ_LOOKUP) ? S_LKP : S_RM1;
        end
      end
      S_LKP: begin
        res_st_nxt  = gsm_pkg::ST_OK;
        res_id_nxt  = id_r;
        res_gen_nxt = gen_r;
        res_pos_nxt = pos_r;
        res_pay_nxt = dd_rd_r;
        state_nxt   = S_PUSH;
      end
      S_RM1: begin
        opay_nxt  = dd_rd_r;
        ls_nxt    = d2s_rd_r;
        state_nxt = S_RM2;
      end
      S_RM2: begin
        dd_we         = 1'b1;
        d2s_we        = 1'b1;
        s2d_we        = 1'b1;
        s2d_wa        = ls_r;
        gen_we        = 1'b1;
        gen_wa        = id_r;
        gen_wd        = gen_r + 1'b1;
        fctl.free_one = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        res_st_nxt    = gsm_pkg::ST_OK;
        res_id_nxt    = id_r;
        res_gen_nxt   = gen_r;
        res_pos_nxt   = pos_r;
        res_pay_nxt   = opay_r;
        state_nxt     = S_PUSH;
      end
      S_CLR: begin
        gen_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == IDW'(CAPACITY - 1)) begin
          res_st_nxt  = gsm_pkg::ST_OK;
          res_id_nxt  = '0;
          res_gen_nxt = '0;
          res_pos_nxt = '0;
          res_pay_nxt = '0;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    id_r      <= id_nxt;
    hgen_r    <= hgen_nxt;
    pay_r     <= pay_nxt;
    pos_r     <= pos_nxt;
    gen_r     <= gen_nxt;
    opay_r    <= opay_nxt;
    ls_r      <= ls_nxt;
    sl_r      <= sl_nxt;
    res_st_r  <= res_st_nxt;
    res_id_r  <= res_id_nxt;
    res_gen_r <= res_gen_nxt;
    res_pos_r <= res_pos_nxt;
    res_pay_r <= res_pay_nxt;
    if (out_load) begin
      out_st_r   <= res_st_r;
      out_id_r   <= res_id_r;
      out_gen_r  <= res_gen_r;
      out_pos_r  <= res_pos_r;
      out_pay_r  <= res_pay_r;
      out_live_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    gen_rd_r <= gen_mem[gen_ra];
  end

  always_ff @(posedge clk) begin
    if (s2d_we) begin
      s2d_mem[s2d_wa] <= s2d_wd;
    end
    s2d_rd_r <= s2d_mem[s2d_ra];
  end

  always_ff @(posedge clk) begin
    if (d2s_we) begin
      d2s_mem[d2s_wa] <= d2s_wd;
    end
    d2s_rd_r <= d2s_mem[d2s_ra];
  end

  always_ff @(posedge clk) begin
    if (dd_we) begin
      dd_mem[dd_wa] <= dd_wd;
    end
    dd_rd_r <= dd_mem[dd_ra];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.out_id         = out_id_r;
  assign out_ch.out_generation = out_gen_r;
  assign out_ch.dense_position = out_pos_r;
  assign out_ch.out_payload    = out_pay_r;
  assign out_ch.live_entries   = out_live_r;

endmodule
`default_nettype wire

>>> rtl/gsm_free_trk.sv
// Free-slot flags with a two-step lowest-free search (group, then bit).
// Depends on gsm_pkg.
`default_nettype none
module gsm_free_trk #(
  parameter int CAPACITY = 64,
  parameter int IDW      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gsm_pkg::free_ctl_t ctl,
  input  wire logic [IDW-1:0]    slot_id,
  output logic [IDW-1:0]         found_slot,
  output logic                   slot_is_free
);

  localparam int GS   = gsm_pkg::GRP_SIZE;
  localparam int BW   = gsm_pkg::GRP_BITS;
  localparam int NG   = ((2 ** IDW) + GS - 1) / GS;
  localparam int FLEN = NG * GS;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;

  logic [FLEN-1:0]     free_r, free_nxt, free_init;
  logic [NG-1:0]       grp_any;
  logic [GIW-1:0]      grp_r, grp_nxt, grp_sel;
  logic [GS-1:0]       grp_vec;
  logic [BW-1:0]       bit_sel;
  logic [GIW+BW-1:0]   slot_full;

  always_comb begin
    for (int i = 0; i < FLEN; i++) begin
      free_init[i] = (i < CAPACITY);
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = |free_r[g*GS +: GS];
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GIW'(g);
      end
    end
  end

  assign grp_vec = free_r[{grp_r, {BW{1'b0}}} +: GS];

  always_comb begin
    bit_sel = '0;
    for (int b = GS - 1; b >= 0; b--) begin
      if (grp_vec[b]) begin
        bit_sel = BW'(b);
      end
    end
  end

  assign slot_full    = {grp_r, bit_sel};
  assign found_slot   = slot_full[IDW-1:0];
  assign slot_is_free = free_r[slot_id];
  assign grp_nxt      = ctl.find_grp ? grp_sel : grp_r;

  always_comb begin
    free_nxt = free_r;
    if (ctl.set_all) begin
      free_nxt = free_init;
    end else begin
      if (ctl.alloc) begin
        free_nxt[found_slot] = 1'b0;
      end
      if (ctl.free_one) begin
        free_nxt[slot_id] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= free_init;
    end else begin
      free_r <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule
`default_nettype wire

>>> verif/slot_map_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the generational slot map testbench: a handle-table predictor
// and an in-order queue of the responses still due. Depends on gsm_pkg.
package slot_map_tb_pkg;
  import gsm_pkg::*;

  localparam int SLOTS     = 64;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  id;
    logic [15:0] gen;
    logic [31:0] data;
  } map_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  id;
    logic [15:0] gen;
    logic [5:0]  pos;
    logic [31:0] data;
    logic [6:0]  live;
  } map_rsp_t;

  class slot_map_scoreboard;
    bit          slot_is_free [SLOTS];
    logic [15:0] slot_gen     [SLOTS];
    logic [5:0]  slot_pos     [SLOTS];
    logic [31:0] dense_data   [SLOTS];
    logic [5:0]  dense_slot   [SLOTS];
    int unsigned live_count;
    map_rsp_t    responses_due [$];
    int unsigned mismatches;
    int unsigned compared;
    int unsigned peak_live;
    int unsigned full_seen;
    int unsigned stale_seen;
    int unsigned kind_seen [4];

    function new();
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
        slot_is_free[i] = 1'b1;
        slot_gen[i]     = '0;
      end
      live_count = 0;
    endfunction

    function bit is_live(logic [5:0] id, logic [15:0] gen);
      return !slot_is_free[id] && slot_gen[id] == gen;
    endfunction

    function int unsigned pending();
      return responses_due.size();
    endfunction

    function void apply_request(map_req_t r);
      map_rsp_t    e;
      logic [5:0]  s;
      logic [5:0]  moved;
      int unsigned pos;
      int unsigned last;
      bit          found;
      e = '0;
      s = '0;
      found = 1'b0;
      kind_seen[r.kind]++;
      case (r.kind)
        REQ_ADD: begin
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (slot_is_free[i]) begin
              s = i[5:0];
              found = 1'b1;
            end
          end
          if (live_count >= SLOTS || !found) begin
            e.status = ST_FULL;
          end else begin
            pos = live_count;
            slot_pos[s] = pos[5:0];
            dense_slot[pos] = s;
            dense_data[pos] = r.data;
            slot_is_free[s] = 1'b0;
            live_count++;
            e.status = ST_OK;
            e.id     = s;
            e.gen    = slot_gen[s];
            e.pos    = pos[5:0];
            e.data   = r.data;
          end
        end
        REQ_REMOVE, REQ_LOOKUP: begin
          if (!is_live(r.id, r.gen) || live_count == 0 || slot_pos[r.id] >= live_count) begin
            e.status = ST_STALE;
          end else if (r.kind == REQ_LOOKUP) begin
            pos      = slot_pos[r.id];
            e.status = ST_OK;
            e.id     = r.id;
            e.gen    = slot_gen[r.id];
            e.pos    = pos[5:0];
            e.data   = dense_data[pos];
          end else begin
            pos   = slot_pos[r.id];
            last  = live_count - 1;
            moved = dense_slot[last];
            e.status = ST_OK;
            e.id     = r.id;
            e.gen    = slot_gen[r.id];
            e.pos    = pos[5:0];
            e.data   = dense_data[pos];
            dense_data[pos] = dense_data[last];
            dense_slot[pos] = moved;
            slot_pos[moved] = pos[5:0];
            slot_gen[r.id]  = slot_gen[r.id] + 16'd1;
            slot_is_free[r.id] = 1'b1;
            live_count = last;
          end
        end
        default: begin
          clear_table();
          e.status = ST_OK;
        end
      endcase
      e.live = live_count[6:0];
      if (e.status == ST_FULL) full_seen++;
      if (e.status == ST_STALE) stale_seen++;
      if (live_count > peak_live) peak_live = live_count;
      responses_due.push_back(e);
    endfunction

    function void check_response(map_rsp_t got);
      map_rsp_t e;
      compared++;
      if (responses_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected response beat: status=%0d id=%0d gen=%0d pos=%0d data=%h live=%0d",
                   got.status, got.id, got.gen, got.pos, got.data, got.live);
        return;
      end
      e = responses_due.pop_front();
      if (got.status !== e.status || got.id !== e.id || got.gen !== e.gen ||
          got.pos !== e.pos || got.data !== e.data || got.live !== e.live) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("response mismatch #%0d", mismatches);
          $display("  expected: status=%0d id=%0d gen=%0d pos=%0d data=%h live=%0d",
                   e.status, e.id, e.gen, e.pos, e.data, e.live);
          $display("  actual:   status=%0d id=%0d gen=%0d pos=%0d data=%h live=%0d",
                   got.status, got.id, got.gen, got.pos, got.data, got.live);
        end
      end
    endfunction
  endclass

endpackage

>>> verif/generational_slot_map_unit_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for generational_slot_map_unit: directed and random requests
// checked in order against the scoreboard. Depends on gsm_pkg, gsm_if, slot_map_tb_pkg.
module generational_slot_map_unit_tb;
  import gsm_pkg::*;
  import slot_map_tb_pkg::*;

  localparam int RANDOM_ITEMS  = 1130;
  localparam int TAIL_ITEMS    = 150;
  localparam int HOLD_AT       = 400;
  localparam int DRAIN_AT      = 700;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = SLOTS + 16;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;
  bit   long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  slot_map_scoreboard sb = new();

  gsm_req_if #(.IDW(6), .GENW(16), .PAYW(32)) in_ch ();
  gsm_rsp_if #(.IDW(6), .GENW(16), .PAYW(32), .CNTW(7)) out_ch ();

  generational_slot_map_unit #(
    .CAPACITY(SLOTS),
    .GEN_BITS(16),
    .PAYLOAD_BITS(32)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("generational_slot_map_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic map_req_t mk(logic [1:0] kind, logic [5:0] id, logic [15:0] gen,
                                  logic [31:0] data);
    map_req_t r;
    r.kind = kind;
    r.id   = id;
    r.gen  = gen;
    r.data = data;
    return r;
  endfunction

  function automatic map_req_t pick_request(int add_pct);
    map_req_t    r;
    int unsigned roll;
    int unsigned p;
    r = mk(REQ_ADD, 6'($urandom), 16'($urandom), $urandom);
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      case ($urandom_range(0, 15))
        0: r.data = '0;
        1: r.data = '1;
        default: ;
      endcase
      return r;
    end
    r.kind = $urandom_range(0, 1) ? REQ_REMOVE : REQ_LOOKUP;
    roll = $urandom_range(0, 99);
    if (roll < 3 && add_pct < 50) begin
      r.kind = REQ_CLEAR;
    end else if (roll < 72 && sb.live_count != 0) begin
      p = $urandom_range(0, sb.live_count - 1);
      r.id  = sb.dense_slot[p];
      r.gen = sb.slot_gen[r.id];
      if (roll >= 62) r.gen = r.gen ^ (16'd1 << $urandom_range(0, 15));
    end else if (roll < 86) begin
      r.gen = sb.slot_gen[r.id] - 16'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic send_item(map_req_t r);
    in_ch.valid             <= 1'b1;
    in_ch.req_type          <= r.kind;
    in_ch.handle_id         <= r.id;
    in_ch.handle_generation <= r.gen;
    in_ch.payload           <= r.data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.apply_request(r);
  endtask

  initial begin
    int  add_pct;
    bit  idle_on;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ADD;
    in_ch.handle_id = '0;
    in_ch.handle_generation = '0;
    in_ch.payload = '0;
    idle_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_item(mk(REQ_LOOKUP, 6'd0, 16'd0, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd63, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk(REQ_ADD, 6'd63, 16'hFFFF, 32'h0000_0000));
    send_item(mk(REQ_ADD, 6'd0, 16'd0, 32'hFFFF_FFFF));
    send_item(mk(REQ_ADD, 6'd0, 16'd0, 32'hA5A5_5A5A));
    send_item(mk(REQ_ADD, 6'd0, 16'd0, 32'h8000_0001));
    send_item(mk(REQ_LOOKUP, 6'd0, 16'd0, 32'd0));
    send_item(mk(REQ_LOOKUP, 6'd3, 16'd0, 32'd0));
    send_item(mk(REQ_LOOKUP, 6'd1, 16'h8000, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd1, 16'd0, 32'd0));
    send_item(mk(REQ_LOOKUP, 6'd3, 16'd0, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd1, 16'd0, 32'd0));
    send_item(mk(REQ_LOOKUP, 6'd1, 16'd1, 32'd0));
    send_item(mk(REQ_ADD, 6'd0, 16'd0, 32'h1234_5678));
    send_item(mk(REQ_LOOKUP, 6'd1, 16'd1, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd1, 16'd1, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd0, 16'd0, 32'd0));
    send_item(mk(REQ_CLEAR, 6'h2A, 16'h5555, 32'h5555_5555));
    send_item(mk(REQ_LOOKUP, 6'd3, 16'd0, 32'd0));
    send_item(mk(REQ_ADD, 6'h15, 16'hAAAA, 32'hAAAA_AAAA));
    send_item(mk(REQ_REMOVE, 6'd0, 16'd0, 32'd0));
    send_item(mk(REQ_REMOVE, 6'd0, 16'd0, 32'd0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - TAIL_ITEMS);
      case ((i / 120) % 3)
        0: add_pct = 75;
        1: add_pct = 45;
        default: add_pct = 20;
      endcase
      if (i % 100 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (i == HOLD_AT) long_hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_item(pick_request(add_pct));
      if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests: %0d add, %0d remove, %0d lookup, %0d clear; %0d full, %0d stale",
             sb.kind_seen[REQ_ADD], sb.kind_seen[REQ_REMOVE], sb.kind_seen[REQ_LOOKUP],
             sb.kind_seen[REQ_CLEAR], sb.full_seen, sb.stale_seen);
    $display("responses compared: %0d, peak occupancy %0d of %0d, mismatches %0d",
             sb.compared, sb.peak_live, SLOTS, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("generational_slot_map_unit_tb: done, clean");
    end else begin
      $display("generational_slot_map_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned cyc;
    bit          stall_on;
    bit          next_ready;
    bit          long_hold_done;
    map_rsp_t    got;
    out_ch.ready = 1'b0;
    hold_left = 0;
    cyc = 0;
    stall_on = 1'b1;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.id     = out_ch.out_id;
        got.gen    = out_ch.out_generation;
        got.pos    = out_ch.dense_position;
        got.data   = out_ch.out_payload;
        got.live   = out_ch.live_entries;
        sb.check_response(got);
      end
      cyc++;
      if (cyc % 200 == 0) stall_on = $urandom_range(0, 2) != 0;
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        next_ready = 1'b0;
      end else if (!quiet && stall_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 5);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

endmodule
